### sv/ecg_pkg.sv
// package with widths, register indexes and the quarter-wave sine table function
`default_nettype none
package ecg_pkg;
   localparam int SineTableBitsDefault = 10;
   localparam int FreqWidth = 32;
   localparam int OutWidth = 16;
   localparam int IndexWidth = 24;
   localparam int LengthWidth = 25;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_START_FREQ   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GROWTH_RATIO = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PHASE_GAIN   = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SWEEP_LENGTH = 2'd3;

   localparam logic [31:0] START_FREQ_RESET   = 32'd65536;
   localparam logic [31:0] GROWTH_RATIO_RESET = 32'd1073741824;
   localparam logic [31:0] PHASE_GAIN_RESET   = 32'd16777216;
   localparam logic [24:0] SWEEP_LENGTH_RESET = 25'd1024;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DONE
   } state_type;

   // quarter-wave sine entry, series in q30 with truncation, evaluated at elaboration
   function automatic logic [15:0] quarter_sine(input int unsigned i, input int unsigned quarter);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] v;
      x = (64'd1686629713 * 64'(i)) / 64'(quarter);
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = 64'd0;
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) neg = neg + term;
         else pos = pos + term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[15:0];
   endfunction
endpackage
`default_nettype wire

### sv/ecg_serial_mul.sv
// bit-serial two's-complement signed multiplier, one multiplier bit a cycle
`default_nettype none
module ecg_serial_mul #(
   parameter int AWidth = 33,
   parameter int BWidth = 33
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [AWidth-1:0]         a,
   input  wire logic [BWidth-1:0]         b,
   output logic                           done,
   output logic [AWidth+BWidth-1:0]       product
);
   localparam int PWidth = AWidth + BWidth;
   localparam int CntWidth = $clog2(BWidth + 1);

   logic [PWidth-1:0]   acc_ff, acc_in;
   logic [PWidth-1:0]   mcand_ff, mcand_in;
   logic [BWidth-1:0]   mplier_ff, mplier_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = PWidth'(signed'(a));
         mplier_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // two's complement: top multiplier bit carries negative weight
         if (mplier_ff[0]) begin
            if (cnt_ff == CntWidth'(BWidth - 1)) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(BWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

### sv/exponential_chirp_generator.sv
// top level of the exponential sine-sweep generator
`default_nettype none
// channel  direction  ports
// req      in         req_valid, req_stall, req_restart
// rsp      out        rsp_valid, rsp_stall, rsp_excitation, rsp_phase_turns,
//                     rsp_frequency, rsp_end_of_sweep
// csr      in         csr_write, csr_index, csr_data
// each sample takes two passes of a 33-bit serial multiplier (phase product, then
// next frequency), one bit per cycle, before the next transfer is taken; the result is
// registered to the outputs after both passes once the output is free; req_stall is high until then
// a sample waits in the output register while the next transfer is taken
// reset is synchronous and restores registers, frequency and index
module exponential_chirp_generator
   import ecg_pkg::*;
#(
   parameter int SineTableBits = ecg_pkg::SineTableBitsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_restart,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [ecg_pkg::OutWidth-1:0]      rsp_excitation,
   output logic [ecg_pkg::OutWidth-1:0]             rsp_phase_turns,
   output logic [ecg_pkg::FreqWidth-1:0]            rsp_frequency,
   output logic                                     rsp_end_of_sweep,
   input  wire logic                                csr_write,
   input  wire logic [ecg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [ecg_pkg::CsrDataWidth-1:0]    csr_data
);
   import ecg_pkg::*;

   localparam int Quarter = 1 << (SineTableBits - 2);
   localparam int OffWidth = SineTableBits - 2;

   function automatic logic [15:0] tab_entry(input logic [OffWidth:0] idx);
      logic [15:0] r;
      r = '0;
      for (int i = 0; i <= Quarter; i++)
         if (idx == (OffWidth + 1)'(i)) r = quarter_sine(i, Quarter);
      return r;
   endfunction

   logic [31:0] start_freq_ff, growth_ratio_ff, phase_gain_ff;
   logic [24:0] sweep_length_ff;
   logic [31:0] cur_freq_ff, cur_freq_in;
   logic [23:0] index_ff, index_in;
   state_type   state_ff, state_in;
   logic        pass_ff, pass_in;
   logic        rsp_valid_ff;
   logic [15:0] exc_ff, phase_ff;
   logic [31:0] freq_ff;
   logic        eos_ff;
   logic [15:0] phase_hold_ff, phase_hold_in;
   logic        eos_hold_ff, eos_hold_in;
   logic [31:0] next_freq_ff;
   logic [15:0] exc_out_ff;

   logic        mul_start;
   logic [32:0] mul_a, mul_b;
   logic        mul_done;
   logic [65:0] mul_p;

   ecg_serial_mul #(.AWidth(33), .BWidth(33)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
   );

   logic        req_xfer, out_free;
   logic [31:0] eff_freq;
   logic [23:0] eff_index;
   logic [24:0] last;
   logic [SineTableBits-1:0] top;
   logic [OffWidth-1:0]      off;
   logic [15:0]              mag, sine;
   logic [33:0]              next_wide;
   logic [31:0]              next_freq;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer = req_valid && !req_stall;
   assign eff_freq = req_restart ? start_freq_ff : cur_freq_ff;
   assign eff_index = req_restart ? '0 : index_ff;
   assign last = sweep_length_ff - 25'd1;

   assign top = mul_p[39:40-SineTableBits];
   assign off = top[OffWidth-1:0];
   assign mag = top[OffWidth] ? tab_entry((OffWidth + 1)'(Quarter) - {1'b0, off})
                              : tab_entry({1'b0, off});
   assign sine = top[OffWidth+1] ? 16'(-mag) : mag;
   assign next_wide = 34'((mul_p[63:0] + 64'd536870912) >> 30);
   assign next_freq = (next_wide[33:32] != 2'b00) ? 32'hFFFF_FFFF : next_wide[31:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_MUL;
         ST_MUL:  if (mul_done && pass_ff) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      pass_in = pass_ff;
      cur_freq_in = cur_freq_ff;
      index_in = index_ff;
      phase_hold_in = phase_hold_ff;
      eos_hold_in = eos_hold_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mul_start = 1'b1;
               mul_a = {1'b0, eff_freq} - {1'b0, start_freq_ff};
               mul_b = {phase_gain_ff[31], phase_gain_ff};
               pass_in = 1'b0;
               cur_freq_in = eff_freq;
               index_in = eff_index;
               eos_hold_in = ({1'b0, eff_index} == last);
            end
         end
         ST_MUL: begin
            if (mul_done && !pass_ff) begin
               phase_hold_in = mul_p[39:24];
               mul_start = 1'b1;
               mul_a = {1'b0, cur_freq_ff};
               mul_b = {1'b0, growth_ratio_ff};
               pass_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cur_freq_in = next_freq_ff;
               index_in = index_ff + 24'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_hold_ff <= phase_hold_in;
      eos_hold_ff <= eos_hold_in;
      pass_ff <= pass_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_freq_ff <= START_FREQ_RESET;
         growth_ratio_ff <= GROWTH_RATIO_RESET;
         phase_gain_ff <= PHASE_GAIN_RESET;
         sweep_length_ff <= SWEEP_LENGTH_RESET;
         cur_freq_ff <= START_FREQ_RESET;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_freq_ff <= cur_freq_in;
         index_ff <= index_in;
         if (csr_write) begin
            case (csr_index)
               CSR_START_FREQ:   start_freq_ff <= csr_data;
               CSR_GROWTH_RATIO: growth_ratio_ff <= csr_data;
               CSR_PHASE_GAIN:   phase_gain_ff <= csr_data;
               CSR_SWEEP_LENGTH: sweep_length_ff <= csr_data[24:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_MUL && mul_done && !pass_ff) begin
            exc_ff <= sine;
         end
         if (state_ff == ST_DONE && out_free) begin
            phase_ff <= phase_hold_ff;
            freq_ff <= cur_freq_ff;
            eos_ff <= eos_hold_ff;
         end
         if (state_ff == ST_MUL && mul_done && pass_ff) next_freq_ff <= next_freq;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) exc_out_ff <= exc_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_excitation = exc_out_ff;
   assign rsp_phase_turns = phase_ff;
   assign rsp_frequency = freq_ff;
   assign rsp_end_of_sweep = eos_ff;
endmodule
`default_nettype wire

### tb/tb_exponential_chirp_generator.sv
// self-checking testbench for the exponential chirp generator: directed table, then random sweeps
`timescale 1ns / 1ps
module tb_exponential_chirp_generator;
   import ecg_pkg::*;

   localparam int TableBits = 10;
   localparam int Quarter = 1 << (TableBits - 2);
   localparam int SettleCycles = 120;
   localparam int StallLimit = 5000;
   localparam int RandomPhases = 12;
   localparam int PhaseItems = 157;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      logic signed [15:0] excitation;
      logic [15:0]        phase_turns;
      logic [31:0]        frequency;
      logic               end_of_sweep;
   } sample_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CsrIndexWidth-1:0]   csr_sel;
      logic [CsrDataWidth-1:0]    csr_value;
      logic                       restart;
      logic                       typed;
      sample_type                 sample;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [OutWidth-1:0] rsp_excitation;
   logic [OutWidth-1:0] rsp_phase_turns;
   logic [FreqWidth-1:0] rsp_frequency;
   logic rsp_end_of_sweep;
   logic csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   exponential_chirp_generator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_excitation(rsp_excitation), .rsp_phase_turns(rsp_phase_turns),
      .rsp_frequency(rsp_frequency), .rsp_end_of_sweep(rsp_end_of_sweep),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   logic [15:0] sine_rom [0:Quarter];
   logic [31:0] sweep_start;
   logic [31:0] sweep_ratio;
   logic [31:0] sweep_gain;
   logic [24:0] sweep_len;
   logic [31:0] chirp_freq;
   logic [23:0] chirp_index;

   sample_type pending_samples[$];
   logic item_typed;
   sample_type item_sample;
   bit rsp_taken;
   bit hold_request;
   int hold_left;
   int errors;
   int items_sent;
   int samples_seen;
   int restarts_seen;
   int sweep_ends_seen;
   int saturated_seen;
   int idle_cycles;
   stim_row_type dir_rows[27];

   function automatic logic [15:0] quarter_wave_entry(input int unsigned i);
      logic [63:0] x, x2, term, pos, neg, s, v;
      x = (64'd1686629713 * 64'(i)) / 64'(Quarter);
      x2 = (x * x) >> 30;
      term = x;
      pos = x;
      neg = 0;
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) neg += term;
         else pos += term;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[15:0];
   endfunction

   function automatic sample_type chirp_sample(input logic restart);
      sample_type r;
      logic [63:0] diff, gain, prod, next;
      logic [TableBits-1:0] top;
      logic [15:0] mag;
      logic [24:0] last;
      if (restart) begin
         chirp_freq = sweep_start;
         chirp_index = 0;
      end
      diff = {32'd0, chirp_freq} - {32'd0, sweep_start};
      gain = {{32{sweep_gain[31]}}, sweep_gain};
      prod = diff * gain;
      r.phase_turns = prod[39:24];
      top = r.phase_turns[15 -: TableBits];
      mag = top[TableBits-2] ? sine_rom[Quarter - top[TableBits-3:0]]
                             : sine_rom[top[TableBits-3:0]];
      r.excitation = top[TableBits-1] ? -mag : mag;
      r.frequency = chirp_freq;
      last = sweep_len - 25'd1;
      r.end_of_sweep = ({1'b0, chirp_index} == last);
      next = ({32'd0, chirp_freq} * {32'd0, sweep_ratio} + (64'd1 << 29)) >> 30;
      chirp_freq = (next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : next[31:0];
      chirp_index = chirp_index + 24'd1;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      sample_type want;
      sample_type pred;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred = chirp_sample(req_restart);
            pending_samples.push_back(item_typed ? item_sample : pred);
            items_sent++;
            if (req_restart) restarts_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1;
            samples_seen++;
            if (rsp_end_of_sweep) sweep_ends_seen++;
            if (rsp_frequency == 32'hFFFF_FFFF) saturated_seen++;
            if (pending_samples.size() == 0) begin
               $error("unexpected sample transfer");
               errors++;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_excitation !== want.excitation) begin
                  $error("excitation: expected %0d got %0d", want.excitation, rsp_excitation);
                  errors++;
               end
               if (rsp_phase_turns !== want.phase_turns) begin
                  $error("phase_turns: expected %h got %h", want.phase_turns, rsp_phase_turns);
                  errors++;
               end
               if (rsp_frequency !== want.frequency) begin
                  $error("frequency: expected %h got %h", want.frequency, rsp_frequency);
                  errors++;
               end
               if (rsp_end_of_sweep !== want.end_of_sweep) begin
                  $error("end_of_sweep: expected %b got %b",
                         want.end_of_sweep, rsp_end_of_sweep);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("timeout after %0d cycles with no transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 0;
         if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
         end else begin
            hold_left = $urandom_range(0, 3);
         end
      end
      rsp_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
   end

   task automatic send_sample(input logic restart, input logic typed, input sample_type s);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_restart <= restart;
      item_typed = typed;
      item_sample = s;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] sel, input logic [31:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= sel;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 0;
      case (sel)
         CSR_START_FREQ:   sweep_start = value;
         CSR_GROWTH_RATIO: sweep_ratio = value;
         CSR_PHASE_GAIN:   sweep_gain = value;
         CSR_SWEEP_LENGTH: sweep_len = value[24:0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type wr(input logic [CsrIndexWidth-1:0] sel, input logic [31:0] v);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.csr_sel = sel;
      r.csr_value = v;
      return r;
   endfunction

   function automatic stim_row_type smp(input logic restart, input logic typed,
                                        input logic [31:0] freq, input logic eos);
      stim_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.restart = restart;
      r.typed = typed;
      r.sample.frequency = freq;
      r.sample.end_of_sweep = eos;
      return r;
   endfunction

   initial begin
      logic [31:0] ratio_pick;
      errors = 0;
      items_sent = 0;
      samples_seen = 0;
      restarts_seen = 0;
      sweep_ends_seen = 0;
      saturated_seen = 0;
      idle_cycles = 0;
      rsp_taken = 0;
      hold_request = 0;
      hold_left = 0;
      reset = 1;
      req_valid = 0;
      req_restart = 0;
      rsp_stall = 0;
      csr_write = 0;
      csr_index = CSR_START_FREQ;
      csr_data = 0;
      for (int i = 0; i <= Quarter; i++) sine_rom[i] = quarter_wave_entry(i);
      sweep_start = START_FREQ_RESET;
      sweep_ratio = GROWTH_RATIO_RESET;
      sweep_gain = PHASE_GAIN_RESET;
      sweep_len = SWEEP_LENGTH_RESET;
      chirp_freq = START_FREQ_RESET;
      chirp_index = 0;

      dir_rows = '{
         smp(0, 1, 32'd65536, 0), smp(0, 0, 0, 0), smp(1, 1, 32'd65536, 0), smp(0, 0, 0, 0),
         wr(CSR_SWEEP_LENGTH, 32'd1), smp(1, 1, 32'd65536, 1), smp(0, 0, 0, 0),
         wr(CSR_SWEEP_LENGTH, 32'd0), smp(1, 0, 0, 0), smp(0, 0, 0, 0),
         wr(CSR_START_FREQ, 32'hFFFF_FFFF), wr(CSR_GROWTH_RATIO, 32'hFFFF_FFFF),
         wr(CSR_PHASE_GAIN, 32'h7FFF_FFFF), wr(CSR_SWEEP_LENGTH, 32'd2),
         smp(1, 1, 32'hFFFF_FFFF, 0), smp(0, 1, 32'hFFFF_FFFF, 1), smp(0, 0, 0, 0),
         wr(CSR_START_FREQ, 32'h1234_5678), wr(CSR_GROWTH_RATIO, 32'h2000_0000),
         wr(CSR_PHASE_GAIN, 32'h8000_0000), wr(CSR_SWEEP_LENGTH, 32'h0100_0001),
         smp(1, 1, 32'h1234_5678, 0), smp(0, 0, 0, 0), smp(0, 0, 0, 0),
         wr(CSR_GROWTH_RATIO, 32'd0), smp(1, 0, 0, 0), smp(0, 0, 0, 0)
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            drain_and_settle();
            write_register(dir_rows[i].csr_sel, dir_rows[i].csr_value);
         end else begin
            send_sample(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].sample);
         end
      end

      for (int p = 0; p < RandomPhases; p++) begin
         drain_and_settle();
         ratio_pick = 32'h4000_0000 + $urandom_range(0, 32'h0040_0000) - 32'h0010_0000;
         if (p % 4 == 3) ratio_pick = $urandom;
         write_register(CSR_START_FREQ, (p % 5 == 4) ? $urandom : $urandom_range(0, 32'h00FF_FFFF));
         write_register(CSR_GROWTH_RATIO, ratio_pick);
         write_register(CSR_PHASE_GAIN, $urandom);
         write_register(CSR_SWEEP_LENGTH, (p % 6 == 5) ? $urandom : $urandom_range(2, 40));
         if (p == 2) hold_request = 1;
         send_sample(1, 0, '0);
         for (int n = 1; n < PhaseItems; n++)
            send_sample(($urandom_range(0, 19) == 0), 0, '0);
      end

      drain_and_settle();
      $display("%0d items sent, %0d samples checked, %0d restarts, %0d sweep ends",
               items_sent, samples_seen, restarts_seen, sweep_ends_seen);
      $display("%0d saturated frequencies, %0d random register settings",
               saturated_seen, RandomPhases);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

### sim.f
sv/ecg_pkg.sv
sv/ecg_serial_mul.sv
sv/exponential_chirp_generator.sv
tb/tb_exponential_chirp_generator.sv
